FILE: hdl/arp_pkg.sv
// package: shared types and constants for the arp resolver cache
`default_nettype none
package arp_pkg;
  localparam int unsigned CacheEntriesDef   = 16;
  localparam int unsigned PendingEntriesDef = 8;

  localparam logic [2:0] KindFrame   = 3'd0;
  localparam logic [2:0] KindHit     = 3'd1;
  localparam logic [2:0] KindResolve = 3'd2;
  localparam logic [2:0] KindQueued  = 3'd3;
  localparam logic [2:0] KindDrop    = 3'd4;

  localparam logic [1:0] OpRequest = 2'd1;
  localparam logic [1:0] OpReply   = 2'd2;

  localparam logic [7:0] WaitMax = 8'hFF;
  localparam logic [47:0] BcastMac = 48'hFFFF_FFFF_FFFF;

  localparam logic CfgOwnIp  = 1'b0;
  localparam logic CfgOwnMac = 1'b1;

  // datapath commands from the controller
  typedef struct packed {
    logic load;       // capture input beat
    logic scan_clr;   // reset scan index
    logic scan_c;     // step one cache entry
    logic scan_p;     // step one pending entry
    logic commit;     // apply state update
    logic emit;       // drive one result
    logic [2:0] kind;
    logic last;
  } arp_cmd_t;

  // datapath status to the controller
  typedef struct packed {
    logic is_lookup;
    logic hdr_ok;
    logic is_req;
    logic to_me;
    logic c_done;
    logic p_done;
    logic c_hit;
    logic p_hit;
    logic p_free;
  } arp_stat_t;
endpackage
`default_nettype wire

FILE: hdl/arp_resolver_cache.sv
// top level: arp resolver with ipv4-to-mac cache and pending lookup table
// steps: load, decode, cache scan, pending scan, update, then zero, one or two
// result beats; a bad message ends after decode
// a new item is taken only when idle, after the last beat of the previous one;
// the table scan steps one entry per cycle
// reset clears valid bits, replace pointer and config registers at once; no sweep
// results are single-cycle strobes, the receiver cannot stall
`default_nettype none
module arp_resolver_cache import arp_pkg::*; #(
  parameter int unsigned CacheEntries   = CacheEntriesDef,
  parameter int unsigned PendingEntries = PendingEntriesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        cmd_i,
  input  wire logic [15:0] hw_type_i,
  input  wire logic [15:0] proto_type_i,
  input  wire logic [7:0]  hw_len_i,
  input  wire logic [7:0]  proto_len_i,
  input  wire logic [15:0] opcode_i,
  input  wire logic [47:0] sender_mac_i,
  input  wire logic [31:0] sender_ip_i,
  input  wire logic [31:0] target_ip_i,
  input  wire logic [31:0] lookup_ip_i,
  output logic             result_valid_o,
  output logic [2:0]       kind_o,
  output logic [1:0]       frame_op_o,
  output logic [47:0]      frame_dest_mac_o,
  output logic [31:0]      frame_target_ip_o,
  output logic [31:0]      answer_ip_o,
  output logic [47:0]      answer_mac_o,
  output logic [7:0]       waiter_count_o,
  output logic             last_o
);
  arp_cmd_t  cmd;
  arp_stat_t stat;

  // config writes always accepted
  assign cfg_ready_o = 1'b1;

  arp_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy), .stat_i(stat), .cmd_o(cmd)
  );

  arp_datapath #(.CacheEntries(CacheEntries), .PendingEntries(PendingEntries)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .cfg_we_i(cfg_valid_i), .cfg_idx_i(cfg_index_i[0]), .cfg_data_i,
    .in_cmd_i(cmd_i), .in_hw_type_i(hw_type_i), .in_proto_type_i(proto_type_i),
    .in_hw_len_i(hw_len_i), .in_proto_len_i(proto_len_i), .in_opcode_i(opcode_i),
    .in_sender_mac_i(sender_mac_i), .in_sender_ip_i(sender_ip_i),
    .in_target_ip_i(target_ip_i), .in_lookup_ip_i(lookup_ip_i),
    .strobe_o(result_valid_o), .kind_o, .frame_op_o, .frame_dest_mac_o,
    .frame_target_ip_o, .answer_ip_o, .answer_mac_o, .waiter_count_o, .last_o
  );
endmodule
`default_nettype wire

FILE: hdl/arp_datapath.sv
// datapath: tables, scan logic and result registers
`default_nettype none
module arp_datapath import arp_pkg::*; #(
  parameter int unsigned CacheEntries   = CacheEntriesDef,
  parameter int unsigned PendingEntries = PendingEntriesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire arp_cmd_t    cmd_i,
  output arp_stat_t        stat_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        in_cmd_i,
  input  wire logic [15:0] in_hw_type_i,
  input  wire logic [15:0] in_proto_type_i,
  input  wire logic [7:0]  in_hw_len_i,
  input  wire logic [7:0]  in_proto_len_i,
  input  wire logic [15:0] in_opcode_i,
  input  wire logic [47:0] in_sender_mac_i,
  input  wire logic [31:0] in_sender_ip_i,
  input  wire logic [31:0] in_target_ip_i,
  input  wire logic [31:0] in_lookup_ip_i,
  output logic             strobe_o,
  output logic [2:0]       kind_o,
  output logic [1:0]       frame_op_o,
  output logic [47:0]      frame_dest_mac_o,
  output logic [31:0]      frame_target_ip_o,
  output logic [31:0]      answer_ip_o,
  output logic [47:0]      answer_mac_o,
  output logic [7:0]       waiter_count_o,
  output logic             last_o
);
  localparam int unsigned CW = (CacheEntries > 1) ? $clog2(CacheEntries) : 1;
  localparam int unsigned PW = (PendingEntries > 1) ? $clog2(PendingEntries) : 1;

  logic [31:0] own_ip_q;
  logic [47:0] own_mac_q;
  logic        lk_q, hdr_q, req_q;
  logic [47:0] smac_q;
  logic [31:0] ip_q, tip_q;

  logic [CacheEntries-1:0]   cv_q;
  logic [31:0] cip_q  [CacheEntries];
  logic [47:0] cmac_q [CacheEntries];
  logic [PendingEntries-1:0] pv_q;
  logic [31:0] pip_q  [PendingEntries];
  logic [7:0]  pw_q   [PendingEntries];
  logic [CW-1:0] rp_q;

  logic [CW:0] ci_q;
  logic [PW:0] pi_q;
  logic c_hit_q, c_free_q, p_hit_q, p_free_q;
  logic [CW-1:0] c_slot_q, c_fslot_q;
  logic [PW-1:0] p_slot_q, p_fslot_q;
  logic [47:0] hmac_q;
  logic [7:0]  hw_q;

  logic [CW-1:0] ci;
  logic [PW-1:0] pi;
  assign ci = ci_q[CW-1:0];
  assign pi = pi_q[PW-1:0];

  assign stat_o.is_lookup = lk_q;
  assign stat_o.hdr_ok    = hdr_q;
  assign stat_o.is_req    = req_q;
  assign stat_o.to_me     = (tip_q == own_ip_q);
  assign stat_o.c_done    = (ci_q == (CW+1)'(CacheEntries));
  assign stat_o.p_done    = (pi_q == (PW+1)'(PendingEntries));
  assign stat_o.c_hit     = c_hit_q;
  assign stat_o.p_hit     = p_hit_q;
  assign stat_o.p_free    = p_free_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q <= '0;
      own_mac_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgOwnIp) own_ip_q <= cfg_data_i[31:0];
      else own_mac_q <= cfg_data_i[47:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      lk_q  <= in_cmd_i;
      hdr_q <= (in_hw_type_i == 16'd1) && (in_proto_type_i == 16'h0800) &&
               (in_hw_len_i == 8'd6) && (in_proto_len_i == 8'd4) &&
               ((in_opcode_i == 16'd1) || (in_opcode_i == 16'd2));
      req_q <= (in_opcode_i == 16'd1);
      smac_q <= in_sender_mac_i;
      tip_q  <= in_target_ip_i;
      ip_q   <= in_cmd_i ? in_lookup_ip_i : in_sender_ip_i;
    end
  end

  // one entry compared per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_clr) begin
      ci_q <= '0; pi_q <= '0;
      c_hit_q <= 1'b0; c_free_q <= 1'b0; p_hit_q <= 1'b0; p_free_q <= 1'b0;
    end else begin
      if (cmd_i.scan_c) begin
        ci_q <= ci_q + 1'b1;
        if (cv_q[ci] && cip_q[ci] == ip_q && !c_hit_q) begin
          c_hit_q <= 1'b1; c_slot_q <= ci; hmac_q <= cmac_q[ci];
        end
        if (!cv_q[ci] && !c_free_q) begin
          c_free_q <= 1'b1; c_fslot_q <= ci;
        end
      end
      if (cmd_i.scan_p) begin
        pi_q <= pi_q + 1'b1;
        if (pv_q[pi] && pip_q[pi] == ip_q && !p_hit_q) begin
          p_hit_q <= 1'b1; p_slot_q <= pi; hw_q <= pw_q[pi];
        end
        if (!pv_q[pi] && !p_free_q) begin
          p_free_q <= 1'b1; p_fslot_q <= pi;
        end
      end
      if (cmd_i.commit && lk_q && p_hit_q && hw_q != WaitMax) hw_q <= hw_q + 8'd1;
    end
  end

  logic [CW-1:0] ins_slot;
  assign ins_slot = c_free_q ? c_fslot_q : rp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q <= '0; pv_q <= '0; rp_q <= '0;
    end else if (cmd_i.commit) begin
      if (!lk_q) begin
        if (!c_hit_q) begin
          cv_q[ins_slot] <= 1'b1;
          if (!c_free_q) rp_q <= (rp_q == CW'(CacheEntries-1)) ? '0 : rp_q + 1'b1;
          if (p_hit_q) pv_q[p_slot_q] <= 1'b0;
        end
      end else if (!c_hit_q && !p_hit_q && p_free_q) begin
        pv_q[p_fslot_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (!lk_q) begin
        if (c_hit_q) cmac_q[c_slot_q] <= smac_q;
        else begin
          cip_q[ins_slot] <= ip_q; cmac_q[ins_slot] <= smac_q;
        end
      end else if (!c_hit_q) begin
        if (p_hit_q) begin
          if (pw_q[p_slot_q] != WaitMax) pw_q[p_slot_q] <= pw_q[p_slot_q] + 8'd1;
        end else if (p_free_q) begin
          pip_q[p_fslot_q] <= ip_q; pw_q[p_fslot_q] <= 8'd1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) strobe_o <= 1'b0;
    else strobe_o <= cmd_i.emit;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_o <= cmd_i.kind;
      last_o <= cmd_i.last;
      frame_op_o <= '0; frame_dest_mac_o <= '0; frame_target_ip_o <= '0;
      answer_ip_o <= ip_q; answer_mac_o <= '0; waiter_count_o <= '0;
      case (cmd_i.kind)
        KindFrame: begin
          answer_ip_o <= '0;
          if (lk_q) begin
            frame_op_o <= OpRequest; frame_dest_mac_o <= BcastMac;
            frame_target_ip_o <= ip_q;
          end else begin
            frame_op_o <= OpReply; frame_dest_mac_o <= smac_q;
            frame_target_ip_o <= ip_q;
          end
        end
        KindHit: answer_mac_o <= hmac_q;
        KindResolve: begin answer_mac_o <= smac_q; waiter_count_o <= hw_q; end
        KindQueued: waiter_count_o <= p_hit_q ? hw_q : 8'd1;
        default: ;
      endcase
    end
  end

  logic unused_mac;
  assign unused_mac = ^own_mac_q;
endmodule
`default_nettype wire

FILE: hdl/arp_ctrl.sv
// controller: sequencing of scan, update and result beats
`default_nettype none
module arp_ctrl import arp_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  output logic           busy_o,
  input  wire arp_stat_t stat_i,
  output arp_cmd_t       cmd_o
);
  localparam logic [2:0] SIdle = 3'd0, SDec = 3'd1, SScanC = 3'd2, SScanP = 3'd3,
                         SCommit = 3'd4, SOut1 = 3'd5, SOut2 = 3'd6;
  logic [2:0] st_q, st_d;
  logic first_frame, two;

  // message: optional resolve then optional reply; lookup: hit, queued or drop, or frame then queued
  assign first_frame = stat_i.is_lookup && !stat_i.c_hit && !stat_i.p_hit && stat_i.p_free;
  assign two = stat_i.is_lookup ? first_frame
             : (!stat_i.c_hit && stat_i.p_hit && stat_i.is_req && stat_i.to_me);

  assign busy_o = (st_q != SIdle);

  always_comb begin
    st_d = st_q;
    cmd_o = '0;
    case (st_q)
      SIdle: begin
        cmd_o.load = start_i;
        if (start_i) st_d = SDec;
      end
      SDec: begin
        cmd_o.scan_clr = 1'b1;
        st_d = (stat_i.is_lookup || stat_i.hdr_ok) ? SScanC : SIdle;
      end
      SScanC: begin
        cmd_o.scan_c = 1'b1;
        if (stat_i.c_done) begin cmd_o.scan_c = 1'b0; st_d = SScanP; end
      end
      SScanP: begin
        cmd_o.scan_p = 1'b1;
        if (stat_i.p_done) begin cmd_o.scan_p = 1'b0; st_d = SCommit; end
      end
      SCommit: begin
        cmd_o.commit = 1'b1;
        st_d = SOut1;
      end
      SOut1: begin
        st_d = two ? SOut2 : SIdle;
        cmd_o.last = !two;
        if (stat_i.is_lookup) begin
          cmd_o.emit = 1'b1;
          if (stat_i.c_hit) cmd_o.kind = KindHit;
          else if (stat_i.p_hit) cmd_o.kind = KindQueued;
          else if (stat_i.p_free) cmd_o.kind = KindFrame;
          else cmd_o.kind = KindDrop;
        end else if (!stat_i.c_hit && stat_i.p_hit) begin
          cmd_o.emit = 1'b1; cmd_o.kind = KindResolve;
        end else if (stat_i.is_req && stat_i.to_me) begin
          cmd_o.emit = 1'b1; cmd_o.kind = KindFrame;
        end
      end
      SOut2: begin
        cmd_o.emit = 1'b1; cmd_o.last = 1'b1;
        cmd_o.kind = stat_i.is_lookup ? KindQueued : KindFrame;
        st_d = SIdle;
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= SIdle;
    else st_q <= st_d;
  end

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> st_q == SIdle) else $error("load outside idle");
  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> busy_o) else $error("emit while idle");
  a_commit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> st_q == SOut1) else $error("commit not followed by output");
endmodule
`default_nettype wire

FILE: sim/tb_top.sv
// testbench: arp resolver cache checked against a behavioral cache and pending-table predictor
`default_nettype none
module tb_top;
  import arp_pkg::*;

  localparam logic        CmdMsg    = 1'b0;
  localparam logic        CmdLookup = 1'b1;
  localparam logic [15:0] HwEth     = 16'd1;
  localparam logic [15:0] ProtoIpv4 = 16'h0800;
  localparam logic [7:0]  HwLenEth  = 8'd6;
  localparam logic [7:0]  IpLen     = 8'd4;
  localparam logic [15:0] ArpReq    = 16'd1;
  localparam logic [15:0] ArpRep    = 16'd2;
  localparam int          NCache    = CacheEntriesDef;
  localparam int          NPend     = PendingEntriesDef;
  localparam int          DrainCyc  = NCache + NPend + 16;
  localparam int          PoolSize  = 22;

  typedef struct packed {
    logic        cmd;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  hw_len;
    logic [7:0]  proto_len;
    logic [15:0] opcode;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
    logic [31:0] lookup_ip;
  } arp_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  frame_op;
    logic [47:0] frame_dest_mac;
    logic [31:0] frame_target_ip;
    logic [31:0] answer_ip;
    logic [47:0] answer_mac;
    logic [7:0]  waiter_count;
    logic        last;
  } arp_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;
  arp_item_t   drv = '0;
  logic        result_valid_o;
  arp_res_t    got;

  arp_resolver_cache u_top (
    .clk_i, .rst_ni, .start, .busy,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .cmd_i(drv.cmd), .hw_type_i(drv.hw_type), .proto_type_i(drv.proto_type),
    .hw_len_i(drv.hw_len), .proto_len_i(drv.proto_len), .opcode_i(drv.opcode),
    .sender_mac_i(drv.sender_mac), .sender_ip_i(drv.sender_ip),
    .target_ip_i(drv.target_ip), .lookup_ip_i(drv.lookup_ip),
    .result_valid_o,
    .kind_o(got.kind), .frame_op_o(got.frame_op), .frame_dest_mac_o(got.frame_dest_mac),
    .frame_target_ip_o(got.frame_target_ip), .answer_ip_o(got.answer_ip),
    .answer_mac_o(got.answer_mac), .waiter_count_o(got.waiter_count), .last_o(got.last)
  );

  initial forever #2 clk_i = ~clk_i;

  initial begin
    #2000000;
    $display("timeout waiting for results");
    $display("Regression FAIL");
    $finish;
  end

  // predictor state: host registers, address cache, pending lookup table
  logic [31:0] host_ip;
  logic [47:0] host_mac;
  logic        arp_cv [NCache];
  logic [31:0] arp_cip[NCache];
  logic [47:0] arp_cmac[NCache];
  int          repl_ptr;
  logic        wait_v [NPend];
  logic [31:0] wait_ip[NPend];
  logic [7:0]  wait_cnt[NPend];

  arp_res_t    expected_q[$];
  logic [31:0] ip_pool[PoolSize];
  int          mismatches, items_sent, results_seen;
  int          sender_idle_pct;

  function automatic arp_res_t mk_res(logic [2:0] k, logic [1:0] op, logic [47:0] dm,
                                      logic [31:0] tip, logic [31:0] aip,
                                      logic [47:0] am, logic [7:0] wc);
    arp_res_t r;
    r = '{kind: k, frame_op: op, frame_dest_mac: dm, frame_target_ip: tip,
          answer_ip: aip, answer_mac: am, waiter_count: wc, last: 1'b0};
    return r;
  endfunction

  // works out the result beats an accepted item causes and updates the tables
  task automatic resolve_item(input arp_item_t it);
    arp_res_t out[$];
    int c, p;
    c = -1;
    p = -1;
    if (it.cmd == CmdMsg) begin
      if (it.hw_type == HwEth && it.proto_type == ProtoIpv4 && it.hw_len == HwLenEth &&
          it.proto_len == IpLen && (it.opcode == ArpReq || it.opcode == ArpRep)) begin
        for (int i = 0; i < NCache; i++)
          if (c < 0 && arp_cv[i] && arp_cip[i] == it.sender_ip) c = i;
        if (c >= 0) begin
          arp_cmac[c] = it.sender_mac;
        end else begin
          for (int i = 0; i < NCache; i++)
            if (c < 0 && !arp_cv[i]) c = i;
          if (c < 0) begin
            c = repl_ptr;
            repl_ptr = (repl_ptr + 1) % NCache;
          end
          arp_cv[c] = 1'b1;
          arp_cip[c] = it.sender_ip;
          arp_cmac[c] = it.sender_mac;
          for (int i = 0; i < NPend; i++)
            if (p < 0 && wait_v[i] && wait_ip[i] == it.sender_ip) p = i;
          if (p >= 0) begin
            out = {out, mk_res(KindResolve, '0, '0, '0, it.sender_ip, it.sender_mac,
                               wait_cnt[p])};
            wait_v[p] = 1'b0;
          end
        end
        if (it.opcode == ArpReq && it.target_ip == host_ip)
          out = {out, mk_res(KindFrame, OpReply, it.sender_mac, it.sender_ip, '0, '0, '0)};
      end
    end else begin
      for (int i = 0; i < NCache; i++)
        if (c < 0 && arp_cv[i] && arp_cip[i] == it.lookup_ip) c = i;
      for (int i = 0; i < NPend; i++)
        if (p < 0 && wait_v[i] && wait_ip[i] == it.lookup_ip) p = i;
      if (c >= 0) begin
        out = {out, mk_res(KindHit, '0, '0, '0, it.lookup_ip, arp_cmac[c], '0)};
      end else if (p >= 0) begin
        if (wait_cnt[p] != WaitMax) wait_cnt[p]++;
        out = {out, mk_res(KindQueued, '0, '0, '0, it.lookup_ip, '0, wait_cnt[p])};
      end else begin
        for (int i = 0; i < NPend; i++)
          if (p < 0 && !wait_v[i]) p = i;
        if (p < 0) begin
          out = {out, mk_res(KindDrop, '0, '0, '0, it.lookup_ip, '0, '0)};
        end else begin
          wait_v[p] = 1'b1;
          wait_ip[p] = it.lookup_ip;
          wait_cnt[p] = 8'd1;
          out = {out, mk_res(KindFrame, OpRequest, BcastMac, it.lookup_ip, '0, '0, '0)};
          out = {out, mk_res(KindQueued, '0, '0, '0, it.lookup_ip, '0, 8'd1)};
        end
      end
    end
    if (out.size() > 0) out[out.size()-1].last = 1'b1;
    foreach (out[i]) expected_q = {expected_q, out[i]};
  endtask

  // result checker: every strobe must match the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        arp_res_t e;
        e = expected_q.pop_front();
        if (got !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", e, got);
        end
      end
    end
  end

  // one item: hold start until the block takes it
  task automatic send_item(input arp_item_t it);
    if (sender_idle_pct > 0 && $urandom_range(99, 0) < sender_idle_pct) begin
      @(negedge clk_i) start <= 1'b0;
      repeat ($urandom_range(5, 0)) @(negedge clk_i);
    end
    @(negedge clk_i);
    start <= 1'b1;
    drv <= it;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    resolve_item(it);
    items_sent++;
  endtask

  // let all beats drain, plus the scan time of an item that yields none
  task automatic settle();
    @(negedge clk_i) start <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (DrainCyc) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [63:0] val);
    settle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    if (idx == CfgOwnIp) host_ip = val[31:0];
    else host_mac = val[47:0];
    @(negedge clk_i) cfg_valid_i <= 1'b0;
  endtask

  function automatic arp_item_t arp_msg(logic [15:0] op, logic [31:0] sip,
                                        logic [47:0] smac, logic [31:0] tip);
    arp_item_t it;
    it = '{cmd: CmdMsg, hw_type: HwEth, proto_type: ProtoIpv4, hw_len: HwLenEth,
           proto_len: IpLen, opcode: op, sender_mac: smac, sender_ip: sip,
           target_ip: tip, lookup_ip: {$urandom}};
    return it;
  endfunction

  function automatic arp_item_t lookup(logic [31:0] ip);
    arp_item_t it;
    it = '0;
    it.cmd = CmdLookup;
    it.hw_type = $urandom;
    it.opcode = $urandom;
    it.lookup_ip = ip;
    return it;
  endfunction

  function automatic logic [47:0] rand_mac();
    return {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
  endfunction

  // answers every open lookup so the pending table is empty again
  task automatic flush_pending();
    for (int i = 0; i < NPend; i++)
      if (wait_v[i]) send_item(arp_msg(ArpRep, wait_ip[i], rand_mac(), ~host_ip));
  endtask

  task automatic test_directed();
    arp_item_t it;
    write_reg(CfgOwnIp, 64'hFFFF_FFFF);
    write_reg(CfgOwnMac, 64'hFFFF_FFFF_FFFF);
    // broken headers and unknown opcodes are dropped silently
    it = arp_msg(ArpReq, 32'h0A00_0001, 48'h1, 32'hFFFF_FFFF);
    it.hw_type = 16'hFFFF;     send_item(it);
    it.hw_type = HwEth;  it.proto_type = 16'h86DD; send_item(it);
    it.proto_type = ProtoIpv4; it.hw_len = 8'hFF;  send_item(it);
    it.hw_len = HwLenEth; it.proto_len = 8'd0;     send_item(it);
    it.proto_len = IpLen; it.opcode = 16'd0;       send_item(it);
    it.opcode = 16'hFFFF;                          send_item(it);
    // miss opens a pending entry, repeats join it, reply resolves it
    send_item(lookup(32'h0000_0000));
    send_item(lookup(32'h0000_0000));
    send_item(lookup(32'hFFFF_FFFF));
    send_item(arp_msg(ArpRep, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 32'h0));
    // request aimed at us: resolve plus reply frame, then a cache hit
    send_item(arp_msg(ArpReq, 32'hFFFF_FFFF, 48'h0, 32'hFFFF_FFFF));
    send_item(lookup(32'hFFFF_FFFF));
    send_item(arp_msg(ArpReq, 32'hFFFF_FFFF, 48'h1234_5678_9ABC, 32'hFFFF_FFFF));
    send_item(lookup(32'hFFFF_FFFF));
    // pending table overflow
    for (int i = 0; i < NPend + 2; i++) send_item(lookup(32'hC0A8_0100 + i));
    flush_pending();
  endtask

  task automatic test_cache_replace();
    // more senders than slots, then look the early ones up again
    for (int i = 0; i < NCache + 5; i++)
      send_item(arp_msg(ArpRep, 32'h0A01_0000 + i, rand_mac(), '0));
    for (int i = 0; i < 8; i++) send_item(lookup(32'h0A01_0000 + i));
    flush_pending();
  endtask

  task automatic test_waiter_saturation();
    for (int i = 0; i < 260; i++) send_item(lookup(32'h0A02_0001));
    send_item(arp_msg(ArpReq, 32'h0A02_0001, rand_mac(), host_ip));
  endtask

  task automatic test_random(input int count, input int idle_pct);
    arp_item_t it;
    sender_idle_pct = idle_pct;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(1, 0)) begin
        it = lookup($urandom_range(9, 0) == 0 ? $urandom : ip_pool[$urandom_range(PoolSize-1, 0)]);
      end else begin
        it = arp_msg($urandom_range(1, 0) ? ArpReq : ArpRep,
                     $urandom_range(9, 0) == 0 ? $urandom : ip_pool[$urandom_range(PoolSize-1, 0)],
                     rand_mac(), $urandom_range(2, 0) == 0 ? $urandom : host_ip);
        // some noise: a corrupt header field or odd opcode
        case ($urandom_range(11, 0))
          0: it.hw_type = $urandom;
          1: it.proto_type = $urandom;
          2: it.hw_len = $urandom;
          3: it.proto_len = $urandom;
          4: it.opcode = $urandom;
          default: ;
        endcase
      end
      send_item(it);
    end
    settle();
  endtask

  initial begin
    mismatches = 0;
    items_sent = 0;
    results_seen = 0;
    sender_idle_pct = 0;
    host_ip = '0;
    host_mac = '0;
    repl_ptr = 0;
    for (int i = 0; i < NCache; i++) arp_cv[i] = 1'b0;
    for (int i = 0; i < NPend; i++) wait_v[i] = 1'b0;
    for (int i = 0; i < PoolSize; i++) ip_pool[i] = $urandom;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    test_directed();
    test_cache_replace();
    test_waiter_saturation();
    write_reg(CfgOwnIp, {32'h0, ip_pool[0]});
    write_reg(CfgOwnMac, {16'h0, rand_mac()});
    test_random(510, 35);
    write_reg(CfgOwnIp, 64'h0);
    write_reg(CfgOwnMac, 64'h0);
    test_random(510, 63);
    write_reg(CfgOwnIp, {32'h0, ip_pool[1]});
    test_random(510, 0);
    settle();

    $display("covered %0d items and %0d result beats: header drops, hits, queueing,",
             items_sent, results_seen);
    $display("pending overflow, waiter saturation, cache replacement, %0d mismatches",
             mismatches);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: files.f
hdl/arp_pkg.sv
hdl/arp_datapath.sv
hdl/arp_ctrl.sv
hdl/arp_resolver_cache.sv
sim/tb_top.sv
